>>> src/ipwm_pkg.sv
package ipwm_pkg;

	localparam int unsigned TimeW  = 32;
	localparam int unsigned CountW = 32;
	localparam int unsigned RegIdxW = 2;

	// configuration register indexes
	typedef enum logic [RegIdxW-1:0] {
		REG_ACTIVE_LOW = 2'd0,
		REG_MIN_WIDTH  = 2'd1,
		REG_MAX_WIDTH  = 2'd2
	} reg_idx_t;

	// pulse event codes
	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_ACCEPT = 2'd1,
		EV_SHORT  = 2'd2,
		EV_LONG   = 2'd3
	} pulse_ev_t;

	typedef struct packed {
		logic              active_low;
		logic [TimeW-1:0]  min_width_us;
		logic [TimeW-1:0]  max_width_us;
	} cfg_t;

	typedef struct packed {
		logic [TimeW-1:0]  time_us;
		logic              pin_level;
	} item_t;

	typedef struct packed {
		logic              open_flag;
		logic [TimeW-1:0]  open_start_time;
		logic [TimeW-1:0]  open_time_sum;
		logic [CountW-1:0] accepted_count;
		logic [CountW-1:0] short_count;
		logic [CountW-1:0] long_count;
	} meter_state_t;

	typedef struct packed {
		pulse_ev_t         pulse_event;
		logic [TimeW-1:0]  pulse_width_us;
		logic [TimeW-1:0]  open_time_total_us;
		logic [CountW-1:0] accepted_pulses;
		logic [CountW-1:0] short_rejects;
		logic [CountW-1:0] long_rejects;
		logic              injector_open;
	} result_t;

	localparam cfg_t CFG_RESET = '{
		active_low:   1'b1,
		min_width_us: '0,
		max_width_us: '1
	};

endpackage

>>> src/ipwm_if.sv
interface ipwm_in_if;
	logic                        valid;
	logic                        ready;
	logic [ipwm_pkg::TimeW-1:0]  time_us;
	logic                        pin_level;

	modport source (output valid, output time_us, output pin_level, input ready);
	modport sink   (input valid, input time_us, input pin_level, output ready);
endinterface

interface ipwm_out_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  pulse_event;
	logic [ipwm_pkg::TimeW-1:0]  pulse_width_us;
	logic [ipwm_pkg::TimeW-1:0]  open_time_total_us;
	logic [ipwm_pkg::CountW-1:0] accepted_pulses;
	logic [ipwm_pkg::CountW-1:0] short_rejects;
	logic [ipwm_pkg::CountW-1:0] long_rejects;
	logic                        injector_open;

	modport source (output valid, output pulse_event, output pulse_width_us,
		output open_time_total_us, output accepted_pulses, output short_rejects,
		output long_rejects, output injector_open, input ready);
	modport sink   (input valid, input pulse_event, input pulse_width_us,
		input open_time_total_us, input accepted_pulses, input short_rejects,
		input long_rejects, input injector_open, output ready);
endinterface

interface ipwm_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [ipwm_pkg::RegIdxW-1:0] index;
	logic [ipwm_pkg::TimeW-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/injector_pulse_width_meter_core.sv
// an accepted edge item passes the input register, then the result register
// throughput: one item per cycle unless out_ch.ready stalls; an input
// register and a result register with compare-and-accumulate between them
// reset: arst_n clears all totals, the open flag and both valid bits, and
// restores active_low to 1, minimum width to 0 and maximum width to all ones
module injector_pulse_width_meter_core (
	input  logic               clk,
	input  logic               arst_n,
	ipwm_in_if.sink            in_ch,
	ipwm_out_if.source         out_ch,
	ipwm_cfg_if.sink           cfg_ch
);

	ipwm_pkg::cfg_t         cfg_q;
	ipwm_pkg::meter_state_t st_q;
	ipwm_pkg::meter_state_t st_nxt;
	ipwm_pkg::item_t        item_s1;
	logic                   vld_s1;
	ipwm_pkg::result_t      res;
	ipwm_pkg::result_t      res_s2;
	logic                   vld_s2;
	logic                   adv;
	ipwm_pkg::reg_idx_t     cfg_idx;

	assign cfg_ch.ready = 1'b1;
	assign cfg_idx      = ipwm_pkg::reg_idx_t'(cfg_ch.index);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= ipwm_pkg::CFG_RESET;
		end else if (cfg_ch.valid) begin
			unique case (cfg_idx)
				ipwm_pkg::REG_ACTIVE_LOW: cfg_q.active_low   <= cfg_ch.data[0];
				ipwm_pkg::REG_MIN_WIDTH:  cfg_q.min_width_us <= cfg_ch.data;
				ipwm_pkg::REG_MAX_WIDTH:  cfg_q.max_width_us <= cfg_ch.data;
				default: ;
			endcase
		end
	end

	// handshake: stage 1 moves when the result register is free or drains
	assign adv         = vld_s1 && (!vld_s2 || out_ch.ready);
	assign in_ch.ready = !vld_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			vld_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1.time_us   <= in_ch.time_us;
			item_s1.pin_level <= in_ch.pin_level;
		end
	end

	ipwm_eval u_eval (
		.cfg    (cfg_q),
		.item   (item_s1),
		.st     (st_q),
		.st_nxt (st_nxt),
		.res    (res)
	);

	// meter state, updated once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (adv) begin
			st_q <= st_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= 1'b1;
		end else if (out_ch.ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign out_ch.valid              = vld_s2;
	assign out_ch.pulse_event        = res_s2.pulse_event;
	assign out_ch.pulse_width_us     = res_s2.pulse_width_us;
	assign out_ch.open_time_total_us = res_s2.open_time_total_us;
	assign out_ch.accepted_pulses    = res_s2.accepted_pulses;
	assign out_ch.short_rejects      = res_s2.short_rejects;
	assign out_ch.long_rejects       = res_s2.long_rejects;
	assign out_ch.injector_open      = res_s2.injector_open;

endmodule

>>> src/ipwm_eval.sv
module ipwm_eval (
	input  ipwm_pkg::cfg_t         cfg,
	input  ipwm_pkg::item_t        item,
	input  ipwm_pkg::meter_state_t st,
	output ipwm_pkg::meter_state_t st_nxt,
	output ipwm_pkg::result_t      res
);

	logic                       is_open;
	logic [ipwm_pkg::TimeW-1:0] width;
	logic                       too_short;
	logic                       too_long;
	ipwm_pkg::pulse_ev_t        ev;

	// pin level to open/closed, width modulo 2^32
	assign is_open   = cfg.active_low ? ~item.pin_level : item.pin_level;
	assign width     = item.time_us - st.open_start_time;
	assign too_short = width < cfg.min_width_us;
	assign too_long  = width > cfg.max_width_us;

	// state update and classification
	always_comb begin
		st_nxt = st;
		ev     = ipwm_pkg::EV_NONE;
		if (is_open && !st.open_flag) begin
			st_nxt.open_flag       = 1'b1;
			st_nxt.open_start_time = item.time_us;
		end else if (!is_open && st.open_flag) begin
			st_nxt.open_flag = 1'b0;
			if (!too_short && !too_long) begin
				st_nxt.open_time_sum  = st.open_time_sum + width;
				st_nxt.accepted_count = st.accepted_count + ipwm_pkg::CountW'(1);
				ev = ipwm_pkg::EV_ACCEPT;
			end else if (too_short) begin
				st_nxt.short_count = st.short_count + ipwm_pkg::CountW'(1);
				ev = ipwm_pkg::EV_SHORT;
			end else begin
				st_nxt.long_count = st.long_count + ipwm_pkg::CountW'(1);
				ev = ipwm_pkg::EV_LONG;
			end
		end
	end

	// result item from the updated totals
	always_comb begin
		res.pulse_event        = ev;
		res.pulse_width_us     = (ev == ipwm_pkg::EV_NONE) ? '0 : width;
		res.open_time_total_us = st_nxt.open_time_sum;
		res.accepted_pulses    = st_nxt.accepted_count;
		res.short_rejects      = st_nxt.short_count;
		res.long_rejects       = st_nxt.long_count;
		res.injector_open      = st_nxt.open_flag;
	end

endmodule
